// ----- rtl/rsh_pkg.sv -----
// Package with the constants, types and mixing functions of the region signature hash.
`timescale 1ns / 1ps

package rsh_pkg;

  localparam int unsigned HASH_W    = 64;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned FOLD_SH   = 32;
  localparam int unsigned PRIME_SH  = 40;

  // Index of each descriptor word in mixing order.
  localparam int unsigned W_CLASS  = 0;
  localparam int unsigned W_FLAGS  = 1;
  localparam int unsigned W_LENLOG = 2;
  localparam int unsigned W_ROLE   = 3;
  localparam int unsigned W_LABEL  = 4;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  // The 64-bit prime is 2^40 + 0x1b3; only the low part needs a multiplier.
  localparam logic [8:0]        PRIME_LO  = 9'h1b3;

  typedef logic [HASH_W-1:0] rsh_word_t;
  typedef logic [NUM_WORDS-1:0][HASH_W-1:0] rsh_words_t;

  // Payload that moves from one cell to the next.
  typedef struct packed {
    rsh_word_t  hash;
    rsh_words_t words;
  } rsh_stage_t;

  // Position of the highest set bit; the input is never zero here.
  function automatic logic [5:0] rsh_log2(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  // One round: xor the word in, multiply by the prime, fold the high half down.
  function automatic rsh_word_t rsh_mix(input rsh_word_t h, input rsh_word_t w);
    rsh_word_t  x;
    logic [72:0] lo;
    rsh_word_t  p;
    x  = h ^ w;
    lo = x * PRIME_LO;
    p  = (x << PRIME_SH) + lo[HASH_W-1:0];
    return p ^ (p >> FOLD_SH);
  endfunction

endpackage

// ----- rtl/rsh_cell.sv -----
// One mixing cell of the signature chain: a single round and its stage register.
`timescale 1ns / 1ps

module rsh_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rsh_pkg::rsh_stage_t up_data,
  input  rsh_pkg::rsh_word_t  up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rsh_pkg::rsh_stage_t dn_data
);
  import rsh_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  rsh_stage_t data_r;
  rsh_stage_t data_nxt;
  logic       load;

  // The stage takes a new word whenever it is empty or its word moves on.
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
    if (load) begin
      data_nxt.hash  = rsh_mix(up_data.hash, up_word);
      data_nxt.words = up_data.words;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

`ifndef ASSERT_OFF
  a_round: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> dn_valid &&
      dn_data.hash == rsh_mix($past(up_data.hash), $past(up_word)))
    else $error("cell hash does not match the round of the accepted word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_data))
    else $error("stalled cell changed its word");

  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dn_valid) |-> $past(up_valid))
    else $error("cell became valid without an upstream word");
`endif

endmodule

// ----- rtl/region_signature_hash_top.sv -----
// Region signature hash: a chain of five mixing cells between two valid/ready channels.
//
// Usage: present the five descriptor fields on in_* with in_valid; a word is
// taken at a clock edge where in_valid and in_ready are both high. One 64-bit
// signature, never zero, comes out on out_signature with out_valid for each
// word taken, in the same order.
// The first cell loads the word at the accepting edge and each later cell adds
// one register, so the word passes all five cell registers before out_valid
// rises. Throughput is one word per cycle while out_ready stays high: each cell
// holds one word and passes its hash to the next cell every cycle unless the
// receiver stalls, so the five rounds overlap.
// The floor log2 of the length is formed at the input and travels with the
// other fields.
// When the receiver stalls, each cell holds its word and in_ready falls once
// the chain is full; up to five words wait inside. Reset (rst_n low at a
// clock edge) empties the chain; no word is lost or repeated when the
// receiver drops out_ready.
`timescale 1ns / 1ps

module region_signature_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_region_class,
  input  logic [63:0] in_flag_bits,
  input  logic [63:0] in_length_in_pages,
  input  logic [31:0] in_owner_role,
  input  logic [63:0] in_label_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_signature
);
  import rsh_pkg::*;

  logic       vld   [NUM_WORDS+1];
  logic       rdy   [NUM_WORDS+1];
  rsh_stage_t stage [NUM_WORDS+1];
  rsh_word_t  tail_hash;

  always_comb begin
    stage[0].hash            = FNV_BASIS;
    stage[0].words[W_CLASS]  = {32'd0, in_region_class};
    stage[0].words[W_FLAGS]  = in_flag_bits;
    stage[0].words[W_LENLOG] = {58'd0, rsh_log2(in_length_in_pages | 64'd1)};
    stage[0].words[W_ROLE]   = {32'd0, in_owner_role};
    stage[0].words[W_LABEL]  = in_label_hash;
  end

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];

  for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
    rsh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_data  (stage[g]),
      .up_word  (stage[g].words[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_data  (stage[g+1])
    );
  end

  assign tail_hash         = stage[NUM_WORDS].hash;
  assign out_valid         = vld[NUM_WORDS];
  assign rdy[NUM_WORDS]    = out_ready;
  // A hash of zero is reported as one.
  assign out_signature     = (tail_hash == '0) ? rsh_word_t'(1) : tail_hash;

`ifndef ASSERT_OFF
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_signature != '0)
    else $error("signature of zero reached the output");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while the output is not stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_signature))
    else $error("stalled signature changed");
`endif

endmodule
